### hdl/square_matrix_arith_engine_macros.svh
`ifndef SQUARE_MATRIX_ARITH_ENGINE_MACROS_SVH
`define SQUARE_MATRIX_ARITH_ENGINE_MACROS_SVH
// Same-cycle implication, sampled on clk, off during reset.
`define SMA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sma check failed");
// Next-cycle implication, sampled on clk, off during reset.
`define SMA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sma check failed");
`endif

### hdl/sma_pkg.sv
package sma_pkg;
	localparam int MAX_SIZE_DEF = 8;
	localparam int ACC_W        = 52;

	localparam logic [1:0] OP_WR_LEFT  = 2'd0;
	localparam logic [1:0] OP_WR_RIGHT = 2'd1;
	localparam logic [1:0] OP_COMPUTE  = 2'd2;
	localparam logic [1:0] OP_NONE     = 2'd3;

	localparam logic REG_SIZE = 1'b0;
	localparam logic REG_MODE = 1'b1;

	localparam logic [3:0] SIZE_RST = 4'd8;
	localparam logic [1:0] MODE_RST = 2'd2;
	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_SUB = 2'd1;
	localparam logic [1:0] MODE_MUL = 2'd2;

	typedef enum logic [1:0] {
		KIND_WR_LEFT,
		KIND_WR_RIGHT,
		KIND_ERROR,
		KIND_COMPUTE
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [2:0]         row;
		logic [2:0]         col;
		logic signed [31:0] value;
	} entry_t;

	typedef struct packed {
		logic [3:0] size;
		logic [1:0] mode;
	} cfg_t;

	// Clamp the size register to 1..max_size.
	function automatic logic [3:0] eff_size(logic [3:0] sz, int max_size);
		logic [3:0] r;
		if (sz == 4'd0)
			r = 4'd1;
		else if (int'(sz) > max_size)
			r = 4'(max_size);
		else
			r = sz;
		return r;
	endfunction
endpackage

### hdl/sma_front.sv
module sma_front #(
	parameter int MAX_SIZE = sma_pkg::MAX_SIZE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sma_pkg::cfg_t       cfg,
	input  logic                item_valid,
	output logic                item_stall,
	input  logic [1:0]          operation,
	input  logic [2:0]          row_index,
	input  logic [2:0]          col_index,
	input  logic signed [31:0]  element_value,
	input  logic                pop,
	output logic                head_valid,
	output sma_pkg::entry_t     head
);
	sma_pkg::entry_t ent_q [2];
	logic [1:0]      count_q;
	logic            rd_q;
	logic            wr_q;
	sma_pkg::entry_t cls;
	logic [3:0]      n;
	logic            keep;
	logic            push;
	logic            out_of_range;

	assign n            = sma_pkg::eff_size(cfg.size, MAX_SIZE);
	assign out_of_range = ({1'b0, row_index} >= n) || ({1'b0, col_index} >= n);

	// Classify the item; drop the unused operation code here.
	always_comb begin
		cls.row   = row_index;
		cls.col   = col_index;
		cls.value = element_value;
		keep      = 1'b1;
		unique case (operation)
			sma_pkg::OP_WR_LEFT: begin
				cls.kind = out_of_range ? sma_pkg::KIND_ERROR : sma_pkg::KIND_WR_LEFT;
			end
			sma_pkg::OP_WR_RIGHT: begin
				cls.kind = out_of_range ? sma_pkg::KIND_ERROR : sma_pkg::KIND_WR_RIGHT;
			end
			sma_pkg::OP_COMPUTE: begin
				cls.kind = sma_pkg::KIND_COMPUTE;
			end
			default: begin
				cls.kind = sma_pkg::KIND_COMPUTE;
				keep     = 1'b0;
			end
		endcase
	end

	assign item_stall = (count_q == 2'd2);
	assign push       = item_valid && !item_stall && keep;
	assign head_valid = (count_q != 2'd0);
	assign head       = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			rd_q    <= 1'b0;
			wr_q    <= 1'b0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end
endmodule

### hdl/sma_back.sv
module sma_back #(
	parameter int MAX_SIZE = sma_pkg::MAX_SIZE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sma_pkg::cfg_t       cfg,
	input  logic                head_valid,
	input  sma_pkg::entry_t     head,
	output logic                pop,
	output logic                result_valid,
	input  logic                result_stall,
	output logic signed [31:0]  result_value,
	output logic [2:0]          result_row,
	output logic [2:0]          result_col,
	output logic                last_element,
	output logic                bounds_error
);
	localparam int DEPTH = MAX_SIZE * MAX_SIZE;
	localparam int AW    = (MAX_SIZE > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int AE    = sma_pkg::ACC_W;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_MUL, ST_ACC, ST_EMIT, ST_WB
	} state_t;

	logic signed [31:0] left_mem  [DEPTH];
	logic signed [31:0] right_mem [DEPTH];
	logic signed [31:0] rowbuf_q  [MAX_SIZE];

	state_t             state_q;
	logic [2:0]         i_q, j_q, k_q, w_q;
	logic signed [31:0] lq_q, rq_q;
	logic signed [63:0] prod_q;
	logic signed [AE-1:0] acc_q;
	logic [3:0]         n;
	logic               mul;
	logic               out_free;
	logic               emit_go;
	logic signed [31:0] sat;
	logic               l_we, r_we;
	logic [AW-1:0]      l_wa, r_wa, l_ra, r_ra;
	logic signed [31:0] l_wd;
	logic               k_end, j_end, i_end, w_end;

	function automatic logic [AW-1:0] addr(logic [2:0] r, logic [2:0] c);
		return AW'(int'(r) * MAX_SIZE + int'(c));
	endfunction

	assign n        = sma_pkg::eff_size(cfg.size, MAX_SIZE);
	assign mul      = cfg.mode[1];
	assign out_free = !(result_valid && result_stall);
	assign k_end    = ({1'b0, k_q} == n - 4'd1);
	assign j_end    = ({1'b0, j_q} == n - 4'd1);
	assign i_end    = ({1'b0, i_q} == n - 4'd1);
	assign w_end    = ({1'b0, w_q} == n - 4'd1);

	assign pop = (state_q == ST_IDLE) && head_valid &&
		(head.kind != sma_pkg::KIND_ERROR || out_free);

	// A result register is loaded on an error transfer or an emitted element.
	assign emit_go = (pop && head.kind == sma_pkg::KIND_ERROR) ||
		(state_q == ST_EMIT && out_free);

	// Saturate the wide accumulator to 32 bits.
	always_comb begin
		if (&acc_q[AE-1:31] || ~|acc_q[AE-1:31])
			sat = acc_q[31:0];
		else if (acc_q[AE-1])
			sat = 32'sh8000_0000;
		else
			sat = 32'sh7fff_ffff;
	end

	// Left store takes loads when idle and the finished row on write-back.
	assign l_we = (pop && head.kind == sma_pkg::KIND_WR_LEFT) || (state_q == ST_WB);
	assign l_wa = (state_q == ST_WB) ? addr(i_q, w_q) : addr(head.row, head.col);
	assign l_wd = (state_q == ST_WB) ? rowbuf_q[w_q[CW-1:0]] : head.value;
	assign r_we = pop && head.kind == sma_pkg::KIND_WR_RIGHT;
	assign r_wa = addr(head.row, head.col);
	assign l_ra = addr(i_q, mul ? k_q : j_q);
	assign r_ra = addr(mul ? k_q : i_q, j_q);

	always_ff @(posedge clk) begin
		if (l_we)
			left_mem[l_wa] <= l_wd;
		if (r_we)
			right_mem[r_wa] <= head.value;
		if (state_q == ST_READ) begin
			lq_q <= left_mem[l_ra];
			rq_q <= right_mem[r_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			result_valid <= 1'b0;
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
			w_q          <= '0;
		end else begin
			if (emit_go)
				result_valid <= 1'b1;
			else if (!result_stall)
				result_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop && head.kind == sma_pkg::KIND_ERROR) begin
						result_value <= '0;
						result_row   <= '0;
						result_col   <= '0;
						last_element <= 1'b0;
						bounds_error <= 1'b1;
					end else if (pop && head.kind == sma_pkg::KIND_COMPUTE) begin
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						acc_q   <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_MUL;
				ST_MUL: begin
					prod_q  <= 64'(lq_q) * 64'(rq_q);
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (!mul) begin
						if (cfg.mode == sma_pkg::MODE_ADD)
							acc_q <= AE'(lq_q) + AE'(rq_q);
						else
							acc_q <= AE'(lq_q) - AE'(rq_q);
						state_q <= ST_EMIT;
					end else begin
						// floor by 2^16: drop the low bits of the product
						acc_q <= acc_q + {{(AE-48){prod_q[63]}}, prod_q[63:16]};
						if (k_end) begin
							state_q <= ST_EMIT;
						end else begin
							k_q     <= k_q + 3'd1;
							state_q <= ST_READ;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						result_value          <= sat;
						result_row            <= i_q;
						result_col            <= j_q;
						last_element          <= i_end && j_end;
						bounds_error          <= 1'b0;
						rowbuf_q[j_q[CW-1:0]] <= sat;
						k_q                   <= '0;
						acc_q                 <= '0;
						if (j_end) begin
							w_q     <= '0;
							state_q <= ST_WB;
						end else begin
							j_q     <= j_q + 3'd1;
							state_q <= ST_READ;
						end
					end
				end
				ST_WB: begin
					w_q <= w_q + 3'd1;
					if (w_end) begin
						if (i_end) begin
							state_q <= ST_IDLE;
						end else begin
							i_q     <= i_q + 3'd1;
							j_q     <= '0;
							state_q <= ST_READ;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### hdl/square_matrix_arith_engine.sv
// Square matrix add/subtract/multiply engine on signed Q16.16 elements.
// Load elements with operation 0 (left) or 1 (right); each load is one transfer
// and, when the queue has room, is taken every cycle. An index at or beyond the
// configured size gives a single result with bounds_error set and stores nothing.
// Operation 2 replaces the left matrix with left+right, left-right or left*right
// (arith_mode; bit 1 selects multiply) and streams it out row-major, last_element
// on the final element. Operation 3 is dropped. A front end classifies items into
// a two-entry queue; the back end walks the single-port stores. Add and subtract
// run read, multiply, accumulate and emit per element; multiply repeats the first
// three per k. Finished rows go back to the left store. The store contents are
// undefined until loaded. Write matrix_size (0x0) and arith_mode (0x4) only idle.
module square_matrix_arith_engine #(
	parameter int MAX_SIZE = sma_pkg::MAX_SIZE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                item_valid,
	output logic                item_stall,
	input  logic [1:0]          operation,
	input  logic [2:0]          row_index,
	input  logic [2:0]          col_index,
	input  logic signed [31:0]  element_value,
	output logic                result_valid,
	input  logic                result_stall,
	output logic signed [31:0]  result_value,
	output logic [2:0]          result_row,
	output logic [2:0]          result_col,
	output logic                last_element,
	output logic                bounds_error
);
	sma_pkg::cfg_t   cfg_q;
	sma_pkg::entry_t head;
	logic            head_valid;
	logic            pop;

	assign pready = 1'b1;
	// Registers sit on a four-byte stride; decode on the word bit only.
	assign prdata = (paddr[2] == sma_pkg::REG_MODE) ? {30'd0, cfg_q.mode} : {28'd0, cfg_q.size};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.size <= sma_pkg::SIZE_RST;
			cfg_q.mode <= sma_pkg::MODE_RST;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == sma_pkg::REG_SIZE)
				cfg_q.size <= pwdata[3:0];
			else
				cfg_q.mode <= pwdata[1:0];
		end
	end

	sma_front #(.MAX_SIZE(MAX_SIZE)) u_front (
		.clk, .arst_n, .cfg(cfg_q), .item_valid, .item_stall, .operation,
		.row_index, .col_index, .element_value, .pop, .head_valid, .head
	);

	sma_back #(.MAX_SIZE(MAX_SIZE)) u_back (
		.clk, .arst_n, .cfg(cfg_q), .head_valid, .head, .pop, .result_valid,
		.result_stall, .result_value, .result_row, .result_col, .last_element,
		.bounds_error
	);
endmodule

### hdl/sma_checker.sv
`include "square_matrix_arith_engine_macros.svh"
module sma_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               pready,
	input logic               result_valid,
	input logic               result_stall,
	input logic signed [31:0] result_value,
	input logic [2:0]         result_row,
	input logic [2:0]         result_col,
	input logic               last_element,
	input logic               bounds_error
);
	`SMA_ASSERT_NEXT(a_hold, result_valid && result_stall, result_valid)
	`SMA_ASSERT_NOW(a_err_clean, result_valid && bounds_error, result_value == 32'sd0 && !last_element)
	`SMA_ASSERT_NOW(a_last_diag, result_valid && last_element, result_row == result_col && !bounds_error)
	`SMA_ASSERT_NOW(a_ready, 1'b1, pready)
endmodule

bind square_matrix_arith_engine sma_checker u_sma_checker (.*);

### dv/matrix_checker.sv
module matrix_checker #(
	parameter int MAX_SIZE = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	input  logic               item_valid,
	input  logic               item_stall,
	input  logic [1:0]         operation,
	input  logic [2:0]         row_index,
	input  logic [2:0]         col_index,
	input  logic signed [31:0] element_value,
	input  logic               result_valid,
	input  logic               result_stall,
	input  logic signed [31:0] result_value,
	input  logic [2:0]         result_row,
	input  logic [2:0]         result_col,
	input  logic               last_element,
	input  logic               bounds_error,
	output int                 fail_count,
	output int                 pending
);
	typedef struct packed {
		logic signed [31:0] value;
		logic [2:0]         row;
		logic [2:0]         col;
		logic               last;
		logic               err;
	} matrix_out_t;

	logic signed [31:0] left_mat [MAX_SIZE*MAX_SIZE];
	logic signed [31:0] right_mat [MAX_SIZE*MAX_SIZE];
	logic [3:0]         size_reg;
	logic [1:0]         mode_reg;
	matrix_out_t        expected_out [$];

	assign pending = expected_out.size();

	task automatic report_mismatch(input string what);
		fail_count++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	task automatic apply_item(input logic [1:0] op, input logic [2:0] r, input logic [2:0] c,
			input logic signed [31:0] v);
		int n;
		logic signed [31:0] fresh [MAX_SIZE*MAX_SIZE];
		logic signed [63:0] acc;
		logic signed [63:0] prod;
		matrix_out_t o;
		n = (size_reg == 0) ? 1 : (size_reg > MAX_SIZE ? MAX_SIZE : size_reg);
		if (op == sma_pkg::OP_WR_LEFT || op == sma_pkg::OP_WR_RIGHT) begin
			if (r >= n || c >= n) begin
				o = '0;
				o.err = 1'b1;
				expected_out.push_back(o);
			end else if (op == sma_pkg::OP_WR_LEFT)
				left_mat[r*MAX_SIZE+c] = v;
			else
				right_mat[r*MAX_SIZE+c] = v;
		end else if (op == sma_pkg::OP_COMPUTE) begin
			for (int i = 0; i < n; i++)
				for (int j = 0; j < n; j++) begin
					if (mode_reg == sma_pkg::MODE_ADD)
						acc = 64'(left_mat[i*MAX_SIZE+j]) + 64'(right_mat[i*MAX_SIZE+j]);
					else if (!mode_reg[1])
						acc = 64'(left_mat[i*MAX_SIZE+j]) - 64'(right_mat[i*MAX_SIZE+j]);
					else begin
						acc = 0;
						for (int k = 0; k < n; k++) begin
							prod = 64'(left_mat[i*MAX_SIZE+k]) * 64'(right_mat[k*MAX_SIZE+j]);
							acc += prod >>> 16;
						end
					end
					fresh[i*MAX_SIZE+j] = clamp32(acc);
				end
			for (int i = 0; i < n; i++)
				for (int j = 0; j < n; j++) begin
					left_mat[i*MAX_SIZE+j] = fresh[i*MAX_SIZE+j];
					o.value = fresh[i*MAX_SIZE+j];
					o.row = 3'(i);
					o.col = 3'(j);
					o.last = (i == n-1 && j == n-1);
					o.err = 1'b0;
					expected_out.push_back(o);
				end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		matrix_out_t e;
		if (!arst_n) begin
			size_reg = sma_pkg::SIZE_RST;
			mode_reg = sma_pkg::MODE_RST;
			fail_count = 0;
			expected_out.delete();
			for (int i = 0; i < MAX_SIZE*MAX_SIZE; i++) begin
				left_mat[i] = 0;
				right_mat[i] = 0;
			end
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == sma_pkg::REG_SIZE)
					size_reg = pwdata[3:0];
				else
					mode_reg = pwdata[1:0];
			end
			if (result_valid && !result_stall) begin
				if (expected_out.size() == 0)
					report_mismatch("result with nothing expected");
				else begin
					e = expected_out.pop_front();
					if (result_value !== e.value)
						report_mismatch($sformatf("value %h, expected %h", result_value, e.value));
					if (result_row !== e.row)
						report_mismatch($sformatf("row %0d, expected %0d", result_row, e.row));
					if (result_col !== e.col)
						report_mismatch($sformatf("col %0d, expected %0d", result_col, e.col));
					if (last_element !== e.last)
						report_mismatch($sformatf("last %b, expected %b", last_element, e.last));
					if (bounds_error !== e.err)
						report_mismatch($sformatf("error %b, expected %b", bounds_error, e.err));
				end
			end
			if (item_valid && !item_stall)
				apply_item(operation, row_index, col_index, element_value);
		end
	end
endmodule

### dv/testbench.sv
module testbench;
	localparam int MAX_CYCLES = 3_000_000;

	logic               clk;
	logic               arst_n;
	logic               psel, penable, pwrite, pready;
	logic [2:0]         paddr;
	logic [31:0]        pwdata, prdata;
	logic               item_valid, item_stall;
	logic [1:0]         operation;
	logic [2:0]         row_index, col_index;
	logic signed [31:0] element_value;
	logic               result_valid, result_stall;
	logic signed [31:0] result_value;
	logic [2:0]         result_row, result_col;
	logic               last_element, bounds_error;
	int                 fail_count, pending;
	int                 cycle_count;
	int                 cur_size;
	bit                 long_hold;
	bit                 in_reset;

	square_matrix_arith_engine u_top (.*);

	matrix_checker u_checker (.*);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Hang guard: end the run if it goes on far too long.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > MAX_CYCLES) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// Receiver: stall on its own rhythm; hold off for a long stretch when asked.
	initial begin
		int hold;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (in_reset)
				result_stall <= 1'b0;
			else if (long_hold) begin
				result_stall <= 1'b1;
				for (hold = 0; hold < 300; hold++)
					@(negedge clk);
				long_hold = 0;
				result_stall <= 1'b0;
			end else if (cycle_count % 700 < 200)
				result_stall <= 1'b0;
			else
				result_stall <= ($urandom_range(0, 3) == 0);
		end
	end

	// Write a register over the bus: setup cycle, then access cycle.
	task automatic write_reg(input logic addr_sel, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {addr_sel, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Drop the offer, wait until every expected transfer has come, then settle.
	task automatic drain;
		item_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// Offer one item and hold it until the transfer takes place.
	task automatic send_item(input logic [1:0] op, input logic [2:0] r, input logic [2:0] c,
			input logic [31:0] v);
		item_valid <= 1'b1;
		operation <= op;
		row_index <= r;
		col_index <= c;
		element_value <= v;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic idle_gap(input int cycles);
		item_valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom;
			default: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
		endcase
	endfunction

	// Load every in-range element of both matrices, in bursts with gaps.
	task automatic load_all(input bit wide);
		for (int m = 0; m < 2; m++)
			for (int r = 0; r < cur_size; r++)
				for (int c = 0; c < cur_size; c++) begin
					send_item(m ? sma_pkg::OP_WR_RIGHT : sma_pkg::OP_WR_LEFT, 3'(r), 3'(c),
						wide ? $urandom : rand_value());
					if ($urandom_range(0, 5) == 0)
						idle_gap($urandom_range(1, 4));
				end
	endtask

	task automatic set_config(input int sz, input logic [1:0] md);
		drain();
		write_reg(sma_pkg::REG_SIZE, 32'(sz));
		write_reg(sma_pkg::REG_MODE, 32'(md));
		cur_size = (sz == 0) ? 1 : (sz > 8 ? 8 : sz);
	endtask

	initial begin
		int burst;
		int items;
		bit hold_done;
		logic [1:0] op;
		in_reset = 1;
		long_hold = 0;
		hold_done = 0;
		cycle_count = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_valid = 1'b0;
		operation = '0;
		row_index = '0;
		col_index = '0;
		element_value = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		in_reset = 0;
		@(negedge clk);

		// Directed: reset size 8 multiply, extremes of the fields.
		cur_size = 8;
		load_all(1'b1);
		send_item(sma_pkg::OP_WR_LEFT, 3'd7, 3'd7, 32'h7fffffff);
		send_item(sma_pkg::OP_WR_RIGHT, 3'd7, 3'd7, 32'h80000000);
		send_item(sma_pkg::OP_COMPUTE, 3'd0, 3'd0, 32'h0);
		send_item(sma_pkg::OP_NONE, 3'd7, 3'd7, 32'hffffffff);
		// Size zero acts as one; writes off the edge give errors.
		set_config(0, sma_pkg::MODE_ADD);
		send_item(sma_pkg::OP_WR_LEFT, 3'd0, 3'd0, 32'h7fffffff);
		send_item(sma_pkg::OP_WR_RIGHT, 3'd0, 3'd0, 32'h7fffffff);
		send_item(sma_pkg::OP_WR_LEFT, 3'd1, 3'd0, 32'h1);
		send_item(sma_pkg::OP_WR_RIGHT, 3'd0, 3'd7, 32'h1);
		send_item(sma_pkg::OP_COMPUTE, 3'd0, 3'd0, 32'h0);
		set_config(1, sma_pkg::MODE_SUB);
		send_item(sma_pkg::OP_WR_RIGHT, 3'd0, 3'd0, 32'h7fffffff);
		send_item(sma_pkg::OP_COMPUTE, 3'd0, 3'd0, 32'h0);
		// Oversized size register and mode three.
		set_config(15, sma_pkg::MODE_MUL | sma_pkg::MODE_SUB);
		send_item(sma_pkg::OP_COMPUTE, 3'd0, 3'd0, 32'h0);
		idle_gap(1);

		// Random phases: small sizes mostly, a full-size one now and then.
		// The directed part above offers 140 items.
		items = 140;
		while (items < 420) begin
			set_config(($urandom_range(0, 5) == 0) ? 8 : $urandom_range(1, 4),
				2'($urandom_range(0, 3)));
			load_all(1'b0);
			items += 2 * cur_size * cur_size;
			burst = $urandom_range(4, 20);
			for (int i = 0; i < burst; i++) begin
				case ($urandom_range(0, 9))
					0: op = sma_pkg::OP_NONE;
					1, 2: op = sma_pkg::OP_COMPUTE;
					3, 4, 5: op = sma_pkg::OP_WR_LEFT;
					default: op = sma_pkg::OP_WR_RIGHT;
				endcase
				// Keep writes in range unless this one is meant to overrun.
				if (op != sma_pkg::OP_NONE && op != sma_pkg::OP_COMPUTE &&
						$urandom_range(0, 4) != 0)
					send_item(op, 3'($urandom_range(0, cur_size-1)),
						3'($urandom_range(0, cur_size-1)), rand_value());
				else
					send_item(op, 3'($urandom), 3'($urandom), $urandom);
				items++;
				if ($urandom_range(0, 3) == 0)
					idle_gap($urandom_range(1, 6));
			end
			if (!hold_done && items > 250) begin
				// Block the output behind a compute and keep offering so the queue fills.
				hold_done = 1;
				long_hold = 1;
				send_item(sma_pkg::OP_COMPUTE, 3'd0, 3'd0, 32'h0);
				items++;
				for (int i = 0; i < 6; i++) begin
					send_item(sma_pkg::OP_WR_LEFT, 3'd7, 3'd7, $urandom);
					items++;
				end
			end
		end
		idle_gap(1);
		drain();
		repeat (200) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule
